// File: design/tmre_pkg.sv
// ----------------------------------------------------------------------------
// tmre_pkg
// Shared types, widths and constants of the thrust map gain estimator.
// ----------------------------------------------------------------------------
package tmre_pkg;

  // field widths
  localparam int GRAV_W   = 21;
  localparam int HOVER_W  = 16;
  localparam int FORGET_W = 17;
  localparam int AGE_W    = 20;
  localparam int TIME_W   = 32;
  localparam int ACC_W    = 24;
  localparam int THR_W    = 18;
  localparam int GAIN_W   = 24;
  localparam int COV_W    = 64;

  // arithmetic unit widths
  localparam int NUM_W    = 128;
  localparam int DEN_W    = 100;
  localparam int STEP_W   = 8;
  localparam int DELTA_W  = 41;
  localparam int ERR_W    = 44;
  localparam int TE_W     = 62;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 21;

  localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOVER    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FORGET   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OLDEST   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_YOUNGEST = 3'd4;

  // register reset values
  localparam logic [GRAV_W-1:0]   GRAVITY_RST  = 21'd642908;
  localparam logic [HOVER_W-1:0]  HOVER_RST    = 16'd19661;
  localparam logic [FORGET_W-1:0] FORGET_RST   = 17'd65405;
  localparam logic [AGE_W-1:0]    OLDEST_RST   = 20'd45000;
  localparam logic [AGE_W-1:0]    YOUNGEST_RST = 20'd35000;

  localparam int HISTORY_DEPTH_DEF = 100;

  // state reset values
  localparam logic [GAIN_W-1:0] GAIN_MAX = {GAIN_W{1'b1}};
  localparam logic [GAIN_W-1:0] GAIN_RST =
    GAIN_W'((64'(GRAVITY_RST) << 16) / 64'(HOVER_RST));
  localparam logic [COV_W-1:0]  COV_RST  = 64'd1000000 << 32;
  localparam logic [DELTA_W-1:0] DELTA_CAP = 41'h1 << 40;

  localparam logic signed [THR_W-1:0] THR_MAX = 18'sh1FFFF;
  localparam logic signed [THR_W-1:0] THR_MIN = 18'sh20000;

  // operation codes
  typedef enum logic [1:0] {
    OP_CMD = 2'd0,
    OP_EST = 2'd1,
    OP_RST = 2'd2,
    OP_NOP = 2'd3
  } op_t;

  // one queued input beat
  typedef struct packed {
    op_t                      op;
    logic [TIME_W-1:0]        now_us;
    logic signed [ACC_W-1:0]  demanded_acc_z;
    logic signed [ACC_W-1:0]  measured_acc_z;
  } item_t;

  // live configuration
  typedef struct packed {
    logic [GRAV_W-1:0]   gravity;
    logic [HOVER_W-1:0]  hover_fraction;
    logic [FORGET_W-1:0] forgetting;
    logic [AGE_W-1:0]    oldest_age_us;
    logic [AGE_W-1:0]    youngest_age_us;
  } cfg_t;

  // divider request and response
  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
    logic [NUM_W-1:0]  num;
    logic [DEN_W-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quo;
  } div_rsp_t;

endpackage

// File: design/tmre_front.sv
// ----------------------------------------------------------------------------
// tmre_front
// Input side: takes beats, decodes the operation and holds them in a
// two-entry queue for the execution engine.
// ----------------------------------------------------------------------------
module tmre_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [79:0]                    s_tdata,
  input  logic [1:0]                     s_tuser,
  output tmre_pkg::item_t                q_item,
  output logic                           q_valid,
  input  logic                           q_ready
);

  tmre_pkg::item_t fifo [2];
  tmre_pkg::item_t in_item;
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      cnt;
  logic            push;
  logic            pop;

  // decode the beat
  always_comb begin
    in_item.op             = tmre_pkg::op_t'(s_tuser);
    in_item.now_us         = s_tdata[31:0];
    in_item.demanded_acc_z = s_tdata[55:32];
    in_item.measured_acc_z = s_tdata[79:56];
  end

  assign s_tready = (cnt != 2'd2);
  assign q_valid  = (cnt != 2'd0);
  assign q_item   = fifo[rd_ptr];
  assign push     = s_tvalid && s_tready;
  assign pop      = q_valid && q_ready;

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= in_item;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

endmodule

// File: design/tmre_div.sv
// ----------------------------------------------------------------------------
// tmre_div
// Restoring divider, one quotient bit per cycle. The numerator comes in
// left-aligned; steps gives how many of its top bits are consumed.
// ----------------------------------------------------------------------------
module tmre_div (
  input  logic                clk,
  input  logic                rst,
  input  tmre_pkg::div_req_t  req,
  output tmre_pkg::div_rsp_t  rsp
);

  logic                          busy;
  logic                          done;
  logic [tmre_pkg::STEP_W-1:0]   cnt;
  logic [tmre_pkg::DEN_W-1:0]    rem;
  logic [tmre_pkg::DEN_W-1:0]    den;
  logic [tmre_pkg::NUM_W-1:0]    nsh;
  logic [tmre_pkg::NUM_W-1:0]    quo;
  logic [tmre_pkg::DEN_W:0]      trial;
  logic                          ge;

  assign trial = {rem, nsh[tmre_pkg::NUM_W-1]};
  assign ge    = (trial >= {1'b0, den});

  assign rsp.done = done;
  assign rsp.quo  = quo;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == tmre_pkg::STEP_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      cnt <= req.steps;
      rem <= '0;
      nsh <= req.num;
      quo <= '0;
      den <= req.den;
    end else if (busy) begin
      rem <= ge ? tmre_pkg::DEN_W'(trial - {1'b0, den}) : trial[tmre_pkg::DEN_W-1:0];
      nsh <= {nsh[tmre_pkg::NUM_W-2:0], 1'b0};
      quo <= {quo[tmre_pkg::NUM_W-2:0], ge};
      cnt <= cnt - tmre_pkg::STEP_W'(1);
    end
  end

endmodule

// File: design/tmre_back.sv
// ----------------------------------------------------------------------------
// tmre_back
// Execution engine: gain and covariance state, command history ring,
// serial multiplier, divider sequencing and the output register.
// ----------------------------------------------------------------------------
module tmre_back #(
  parameter int HISTORY_DEPTH = tmre_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  tmre_pkg::cfg_t                    cfg,
  input  tmre_pkg::item_t                   q_item,
  input  logic                              q_valid,
  output logic                              q_ready,
  output tmre_pkg::div_req_t                div_req,
  input  tmre_pkg::div_rsp_t                div_rsp,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [tmre_pkg::THR_W-1:0] out_throttle,
  output logic                              out_updated,
  output logic [tmre_pkg::GAIN_W-1:0]       out_gain
);

  localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam int ENT_W = tmre_pkg::TIME_W + tmre_pkg::THR_W;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(HISTORY_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HISTORY_DEPTH - 1);

  typedef enum logic [12:0] {
    S_IDLE    = 13'b0000000000001,
    S_CMD_DIV = 13'b0000000000010,
    S_CMD_WR  = 13'b0000000000100,
    S_RST_DIV = 13'b0000000001000,
    S_EST_RD  = 13'b0000000010000,
    S_EST_CHK = 13'b0000000100000,
    S_RLS_E   = 13'b0000001000000,
    S_RLS_M   = 13'b0000010000000,
    S_MUL_D   = 13'b0000100000000,
    S_MUL_N   = 13'b0001000000000,
    S_DIV_G   = 13'b0010000000000,
    S_DIV_P   = 13'b0100000000000,
    S_DONE    = 13'b1000000000000
  } state_t;

  state_t state;

  // architectural state
  logic [tmre_pkg::GAIN_W-1:0] gain;
  logic [tmre_pkg::COV_W-1:0]  cov;
  logic [IDX_W-1:0]            head;
  logic [CNT_W-1:0]            count;
  logic [ENT_W-1:0]            mem [HISTORY_DEPTH];
  logic [ENT_W-1:0]            rd_data;

  // working registers
  tmre_pkg::item_t                   item;
  logic signed [tmre_pkg::THR_W-1:0] thr;
  logic                              upd;
  logic                              cmd_neg;
  logic signed [tmre_pkg::ERR_W-1:0] e_r;
  logic [tmre_pkg::THR_W-1:0]        tmag_r;
  logic                              neg_r;
  logic [tmre_pkg::TE_W-1:0]         te_r;
  logic [tmre_pkg::NUM_W-1:0]        acc;
  logic [tmre_pkg::NUM_W-1:0]        ash;
  logic [tmre_pkg::COV_W-1:0]        bsh;
  logic [6:0]                        mcnt;
  logic [tmre_pkg::DEN_W-1:0]        d_r;

  // combinational helpers
  logic [tmre_pkg::TIME_W-1:0]        rd_time;
  logic signed [tmre_pkg::THR_W-1:0]  rd_thr;
  logic [tmre_pkg::TIME_W-1:0]        age;
  logic [IDX_W-1:0]                   head_inc;
  logic [CNT_W:0]                     slot_sum;
  logic [IDX_W-1:0]                   slot;
  logic                               full;
  logic [tmre_pkg::ACC_W-1:0]         dem_mag;
  logic signed [42:0]                 tg_c;
  logic signed [tmre_pkg::ERR_W-1:0]  a_sh;
  logic signed [tmre_pkg::ERR_W-1:0]  e_c;
  logic [tmre_pkg::THR_W-1:0]         tmag_c;
  logic [tmre_pkg::ERR_W-1:0]         emag_c;
  logic [tmre_pkg::FORGET_W-1:0]      rho;
  logic [tmre_pkg::DELTA_W-1:0]       cmd_mag;
  logic [tmre_pkg::DELTA_W-1:0]       delta;
  logic signed [42:0]                 g_sum;
  logic [tmre_pkg::GAIN_W-1:0]        g_new;
  logic [tmre_pkg::NUM_W-1:0]         rst_q;

  assign q_ready = (state == S_IDLE);

  assign rd_time = rd_data[tmre_pkg::TIME_W-1:0];
  assign rd_thr  = rd_data[ENT_W-1:tmre_pkg::TIME_W];
  assign age     = item.now_us - rd_time;

  // ring arithmetic
  assign head_inc = (head == LAST_IDX) ? '0 : head + IDX_W'(1);
  assign full     = (count == DEPTH_C);
  assign slot_sum = (CNT_W+1)'(head) + (CNT_W+1)'(count);
  assign slot     = (slot_sum >= (CNT_W+1)'(HISTORY_DEPTH)) ?
                    IDX_W'(slot_sum - (CNT_W+1)'(HISTORY_DEPTH)) : IDX_W'(slot_sum);

  assign dem_mag = q_item.demanded_acc_z[tmre_pkg::ACC_W-1] ?
                   tmre_pkg::ACC_W'(-q_item.demanded_acc_z) :
                   tmre_pkg::ACC_W'(q_item.demanded_acc_z);

  // prediction error: a*2^16 - t*gain
  assign tg_c   = rd_thr * $signed({1'b0, gain});
  assign a_sh   = {{4{item.measured_acc_z[tmre_pkg::ACC_W-1]}}, item.measured_acc_z, 16'b0};
  assign e_c    = a_sh - {tg_c[42], tg_c};
  assign tmag_c = rd_thr[tmre_pkg::THR_W-1] ? tmre_pkg::THR_W'(-rd_thr) :
                  tmre_pkg::THR_W'(rd_thr);
  assign emag_c = e_r[tmre_pkg::ERR_W-1] ? tmre_pkg::ERR_W'(-e_r) : tmre_pkg::ERR_W'(e_r);
  assign rho    = (cfg.forgetting == '0) ? tmre_pkg::FORGET_W'(1) : cfg.forgetting;

  // divider results, saturated
  assign cmd_mag = div_rsp.quo[tmre_pkg::DELTA_W-1:0];
  assign delta   = ((|div_rsp.quo[tmre_pkg::NUM_W-1:tmre_pkg::DELTA_W]) ||
                    (div_rsp.quo[tmre_pkg::DELTA_W-1:0] > tmre_pkg::DELTA_CAP)) ?
                   tmre_pkg::DELTA_CAP : div_rsp.quo[tmre_pkg::DELTA_W-1:0];
  assign g_sum   = neg_r ? $signed({19'b0, gain}) - $signed({2'b0, delta})
                         : $signed({19'b0, gain}) + $signed({2'b0, delta});
  assign g_new   = g_sum[42] ? '0 :
                   (g_sum > $signed({19'b0, tmre_pkg::GAIN_MAX})) ? tmre_pkg::GAIN_MAX :
                   g_sum[tmre_pkg::GAIN_W-1:0];
  assign rst_q   = div_rsp.quo;

  // history memory
  always_ff @(posedge clk) begin
    if (state == S_CMD_WR) begin
      mem[full ? head : slot] <= {thr, item.now_us};
    end
    rd_data <= mem[head];
  end

  // control and state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      gain          <= tmre_pkg::GAIN_RST;
      cov           <= tmre_pkg::COV_RST;
      head          <= '0;
      count         <= '0;
      out_valid     <= 1'b0;
      div_req.start <= 1'b0;
    end else begin
      div_req.start <= 1'b0;
      if (out_valid && out_ready) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            item    <= q_item;
            thr     <= '0;
            upd     <= 1'b0;
            cmd_neg <= q_item.demanded_acc_z[tmre_pkg::ACC_W-1];
            unique case (q_item.op)
              tmre_pkg::OP_CMD: begin
                if (gain == '0) begin
                  thr   <= q_item.demanded_acc_z[tmre_pkg::ACC_W-1] ? tmre_pkg::THR_MIN :
                           (q_item.demanded_acc_z == '0) ? '0 : tmre_pkg::THR_MAX;
                  state <= S_CMD_WR;
                end else begin
                  div_req.start <= 1'b1;
                  div_req.steps <= tmre_pkg::STEP_W'(40);
                  div_req.num   <= {dem_mag, 16'b0, 88'b0};
                  div_req.den   <= tmre_pkg::DEN_W'(gain);
                  state         <= S_CMD_DIV;
                end
              end
              tmre_pkg::OP_EST: begin
                state <= (count == '0) ? S_DONE : S_EST_RD;
              end
              tmre_pkg::OP_RST: begin
                if (cfg.hover_fraction == '0) begin
                  gain  <= tmre_pkg::GAIN_MAX;
                  cov   <= tmre_pkg::COV_RST;
                  state <= S_DONE;
                end else begin
                  div_req.start <= 1'b1;
                  div_req.steps <= tmre_pkg::STEP_W'(37);
                  div_req.num   <= {cfg.gravity, 16'b0, 91'b0};
                  div_req.den   <= tmre_pkg::DEN_W'(cfg.hover_fraction);
                  state         <= S_RST_DIV;
                end
              end
              tmre_pkg::OP_NOP: begin
                state <= S_DONE;
              end
              default: state <= S_DONE;
            endcase
          end
        end

        // throttle = demand * 2^16 / gain, saturated
        S_CMD_DIV: begin
          if (div_rsp.done) begin
            if (cmd_neg) begin
              thr <= (cmd_mag > 41'd131072) ? tmre_pkg::THR_MIN :
                     tmre_pkg::THR_W'(-$signed({1'b0, cmd_mag}));
            end else begin
              thr <= (cmd_mag > 41'd131071) ? tmre_pkg::THR_MAX : tmre_pkg::THR_W'(cmd_mag);
            end
            state <= S_CMD_WR;
          end
        end

        // record the command; a full ring drops its oldest entry
        S_CMD_WR: begin
          if (full) begin
            head <= head_inc;
          end else begin
            count <= count + CNT_W'(1);
          end
          state <= S_DONE;
        end

        S_RST_DIV: begin
          if (div_rsp.done) begin
            gain  <= (|rst_q[tmre_pkg::NUM_W-1:tmre_pkg::GAIN_W]) ? tmre_pkg::GAIN_MAX :
                     rst_q[tmre_pkg::GAIN_W-1:0];
            cov   <= tmre_pkg::COV_RST;
            state <= S_DONE;
          end
        end

        // memory read latency
        S_EST_RD: begin
          state <= S_EST_CHK;
        end

        // drop stale entries, use the front one if old enough
        S_EST_CHK: begin
          if (age > tmre_pkg::TIME_W'(cfg.oldest_age_us)) begin
            head  <= head_inc;
            count <= count - CNT_W'(1);
            state <= (count == CNT_W'(1)) ? S_DONE : S_EST_RD;
          end else if (age >= tmre_pkg::TIME_W'(cfg.youngest_age_us)) begin
            state <= S_RLS_E;
          end else begin
            state <= S_DONE;
          end
        end

        S_RLS_E: begin
          e_r    <= e_c;
          tmag_r <= tmag_c;
          neg_r  <= rd_thr[tmre_pkg::THR_W-1] ^ e_c[tmre_pkg::ERR_W-1];
          state  <= S_RLS_M;
        end

        // t^2 into the serial multiplier, t*|e| kept for later
        S_RLS_M: begin
          ash   <= tmre_pkg::NUM_W'(tmag_r * tmag_r);
          te_r  <= tmre_pkg::TE_W'(tmag_r * emag_c);
          bsh   <= cov;
          acc   <= '0;
          mcnt  <= 7'd64;
          state <= S_MUL_D;
        end

        // shift-add multiply by P, one bit per cycle
        S_MUL_D, S_MUL_N: begin
          if (mcnt == 7'd0) begin
            if (state == S_MUL_D) begin
              d_r   <= tmre_pkg::DEN_W'({rho, 48'b0}) + acc[tmre_pkg::DEN_W-1:0];
              ash   <= tmre_pkg::NUM_W'(te_r);
              bsh   <= cov;
              acc   <= '0;
              mcnt  <= 7'd64;
              state <= S_MUL_N;
            end else begin
              div_req.start <= 1'b1;
              div_req.steps <= tmre_pkg::STEP_W'(128);
              div_req.num   <= acc;
              div_req.den   <= d_r;
              state         <= S_DIV_G;
            end
          end else begin
            if (bsh[0]) acc <= acc + ash;
            ash  <= {ash[tmre_pkg::NUM_W-2:0], 1'b0};
            bsh  <= {1'b0, bsh[tmre_pkg::COV_W-1:1]};
            mcnt <= mcnt - 7'd1;
          end
        end

        // gain step, then P / D
        S_DIV_G: begin
          if (div_rsp.done) begin
            gain          <= g_new;
            div_req.start <= 1'b1;
            div_req.steps <= tmre_pkg::STEP_W'(128);
            div_req.num   <= {cov, 64'b0};
            div_req.den   <= d_r;
            state         <= S_DIV_P;
          end
        end

        S_DIV_P: begin
          if (div_rsp.done) begin
            cov   <= (|div_rsp.quo[tmre_pkg::NUM_W-1:tmre_pkg::COV_W]) ? {tmre_pkg::COV_W{1'b1}}
                     : div_rsp.quo[tmre_pkg::COV_W-1:0];
            head  <= head_inc;
            count <= count - CNT_W'(1);
            upd   <= 1'b1;
            state <= S_DONE;
          end
        end

        // hand the result to the output register
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            out_throttle <= thr;
            out_updated  <= upd;
            out_gain     <= gain;
            state        <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: design/thrust_map_rls_estimator_unit.sv
// ----------------------------------------------------------------------------
// thrust_map_rls_estimator_unit
// Throttle-to-acceleration gain estimator with command history.
// ----------------------------------------------------------------------------
// One beat in gives one beat out. A command divides the demand by the gain,
// if nonzero, and a mapping reset divides gravity by the hover fraction, if
// nonzero, both on the one-bit-per-cycle divider. An estimate examines history
// entries one at a time; when it applies an update it runs two shift-add
// multiplies by the covariance and two 128-step divisions by the same
// divider. A two-beat input queue and the output register let the sides
// stall independently.
module thrust_map_rls_estimator_unit #(
  parameter int HISTORY_DEPTH = tmre_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [79:0]                         s_tdata,  // now_us, demanded_acc_z, measured_acc_z
  input  logic [1:0]                          s_tuser,  // op
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [47:0]                         m_tdata,  // throttle, gain, zero pad
  output logic                                m_tuser,  // updated
  input  logic                                cfg_we,
  input  logic [tmre_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [tmre_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  tmre_pkg::cfg_t                    cfg;
  tmre_pkg::item_t                   q_item;
  logic                              q_valid;
  logic                              q_ready;
  tmre_pkg::div_req_t                div_req;
  tmre_pkg::div_rsp_t                div_rsp;
  logic signed [tmre_pkg::THR_W-1:0] out_throttle;
  logic [tmre_pkg::GAIN_W-1:0]       out_gain;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gravity         <= tmre_pkg::GRAVITY_RST;
      cfg.hover_fraction  <= tmre_pkg::HOVER_RST;
      cfg.forgetting      <= tmre_pkg::FORGET_RST;
      cfg.oldest_age_us   <= tmre_pkg::OLDEST_RST;
      cfg.youngest_age_us <= tmre_pkg::YOUNGEST_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        tmre_pkg::CFG_GRAVITY:  cfg.gravity         <= cfg_wdata;
        tmre_pkg::CFG_HOVER:    cfg.hover_fraction  <= cfg_wdata[tmre_pkg::HOVER_W-1:0];
        tmre_pkg::CFG_FORGET:   cfg.forgetting      <= cfg_wdata[tmre_pkg::FORGET_W-1:0];
        tmre_pkg::CFG_OLDEST:   cfg.oldest_age_us   <= cfg_wdata[tmre_pkg::AGE_W-1:0];
        tmre_pkg::CFG_YOUNGEST: cfg.youngest_age_us <= cfg_wdata[tmre_pkg::AGE_W-1:0];
        default: ;
      endcase
    end
  end

  tmre_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_item   (q_item),
    .q_valid  (q_valid),
    .q_ready  (q_ready)
  );

  tmre_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  tmre_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_item       (q_item),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .div_req      (div_req),
    .div_rsp      (div_rsp),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_throttle (out_throttle),
    .out_updated  (m_tuser),
    .out_gain     (out_gain)
  );

  assign m_tdata = {6'b0, out_gain, out_throttle};

endmodule

// File: design/tmre_chk.sv
// ----------------------------------------------------------------------------
// tmre_chk
// Port-level checks of the gain estimator, bound to the top level.
// ----------------------------------------------------------------------------
module tmre_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic        m_tuser
);

  logic       in_beat;
  logic       out_beat;
  logic [2:0] pend;

  assign in_beat  = s_tvalid && s_tready;
  assign out_beat = m_tvalid && m_tready;

  // beats accepted but not yet answered
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 3'd0;
    end else begin
      pend <= pend + 3'(in_beat) - 3'(out_beat);
    end
  end

  // every result answers an earlier input beat
  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    out_beat |-> pend != 3'd0)
    else $error("result beat with no input outstanding");

  // an update result never carries a throttle
  a_upd_thr: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> m_tdata[17:0] == 18'd0)
    else $error("update result with nonzero throttle");

  // reset empties the output
  a_rst_out: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

endmodule

bind thrust_map_rls_estimator_unit tmre_chk u_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// File: tb/tb_thrust_map_rls_estimator_unit.sv
// ----------------------------------------------------------------------------
// tb_thrust_map_rls_estimator_unit
// Self-checking bench for the throttle gain estimator. Every accepted input
// beat is run through an in-bench model of the command history and the scalar
// RLS update; output beats are compared in order against its predictions.
// Several register settings, random stalls on both streams and wrapping time.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_thrust_map_rls_estimator_unit;

  localparam int       DEPTH     = tmre_pkg::HISTORY_DEPTH_DEF;
  localparam int       MAX_TICKS = 4000000;
  localparam bit [63:0] CAP      = 64'd1 << 40;

  typedef struct {
    bit [31:0] stamp;
    int        thr;
  } cmd_rec_t;

  typedef struct {
    bit [17:0] thr;
    bit        upd;
    bit [23:0] gain;
  } beat_t;

  // gain estimator model plus queue of predicted output beats
  class gain_scoreboard;
    bit [20:0] grav;
    bit [15:0] hover;
    bit [16:0] forget;
    bit [19:0] oldest;
    bit [19:0] youngest;
    bit [23:0] gain;
    bit [63:0] cov;
    cmd_rec_t  hist[$];
    beat_t     pending[$];
    int        errors;
    int        n_upd;
    int        n_out;

    function void power_on();
      grav = tmre_pkg::GRAVITY_RST; hover = tmre_pkg::HOVER_RST;
      forget = tmre_pkg::FORGET_RST;
      oldest = tmre_pkg::OLDEST_RST; youngest = tmre_pkg::YOUNGEST_RST;
      hist.delete(); pending.delete();
      errors = 0; n_upd = 0; n_out = 0;
      remap();
    endfunction

    function void set_reg(bit [2:0] idx, bit [20:0] val);
      case (idx)
        tmre_pkg::CFG_GRAVITY:  grav = val;
        tmre_pkg::CFG_HOVER:    hover = val[15:0];
        tmre_pkg::CFG_FORGET:   forget = val[16:0];
        tmre_pkg::CFG_OLDEST:   oldest = val[19:0];
        tmre_pkg::CFG_YOUNGEST: youngest = val[19:0];
        default: ;
      endcase
    endfunction

    function void remap();
      bit [63:0] g;
      if (hover == 0) gain = '1;
      else begin
        g = (64'(grav) << 16) / 64'(hover);
        gain = (g > 64'hFFFFFF) ? 24'hFFFFFF : g[23:0];
      end
      cov = 64'd1000000 << 32;
    endfunction

    function int throttle_for(longint acc);
      longint q;
      if (gain == 0) return acc > 0 ? 131071 : (acc < 0 ? -131072 : 0);
      q = (acc * 65536) / longint'(gain);
      if (q > 131071) q = 131071;
      if (q < -131072) q = -131072;
      return int'(q);
    endfunction

    // one scalar RLS step, all terms from the old covariance
    function void rls(longint t, longint a);
      bit [63:0]  rho, tmag, emag, delta;
      bit [127:0] d, n, q;
      longint     e, g;
      bit         neg;
      rho  = (forget != 0) ? 64'(forget) : 64'd1;
      tmag = (t < 0) ? -t : t;
      e    = a * 65536 - t * longint'(gain);
      emag = (e < 0) ? -e : e;
      neg  = (t < 0) != (e < 0);
      d = (128'(rho) << 48) + 128'(tmag * tmag) * 128'(cov);
      n = 128'(cov) * 128'(tmag * emag);
      q = n / d;
      delta = (q > 128'(CAP)) ? CAP : q[63:0];
      g = longint'(gain) + (neg ? -longint'(delta) : longint'(delta));
      if (g < 0) g = 0;
      if (g > 64'hFFFFFF) g = 64'hFFFFFF;
      q = {cov, 64'd0} / d;
      cov  = (q[127:64] != 0) ? '1 : q[63:0];
      gain = g[23:0];
    endfunction

    function void note_input(tmre_pkg::op_t op, bit [31:0] now, bit signed [23:0] dem,
                             bit signed [23:0] meas);
      beat_t    b;
      cmd_rec_t r;
      bit [31:0] age;
      b.thr = 0; b.upd = 0;
      case (op)
        tmre_pkg::OP_CMD: begin
          r.thr = throttle_for(longint'(dem));
          r.stamp = now;
          if (hist.size() >= DEPTH) void'(hist.pop_front());
          hist.push_back(r);
          b.thr = r.thr[17:0];
        end
        tmre_pkg::OP_EST: begin
          while (hist.size() > 0) begin
            age = now - hist[0].stamp;
            if (age > 32'(oldest)) begin
              void'(hist.pop_front());
              continue;
            end
            if (age >= 32'(youngest)) begin
              rls(longint'(hist[0].thr), longint'(meas));
              void'(hist.pop_front());
              b.upd = 1;
              n_upd++;
            end
            break;
          end
        end
        tmre_pkg::OP_RST: remap();
        default: ;
      endcase
      b.gain = gain;
      pending.push_back(b);
    endfunction

    function void check_output(bit [17:0] thr, bit upd, bit [23:0] g);
      beat_t e;
      n_out++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected output beat thr=%h upd=%0d gain=%h", $time, thr, upd, g);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (thr !== e.thr) begin
        $display("%0t: throttle mismatch exp=%h act=%h", $time, e.thr, thr);
        errors++;
      end
      if (upd !== e.upd) begin
        $display("%0t: updated mismatch exp=%0d act=%0d", $time, e.upd, upd);
        errors++;
      end
      if (g !== e.gain) begin
        $display("%0t: gain mismatch exp=%h act=%h", $time, e.gain, g);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [79:0] s_tdata = '0;   // now_us, demanded_acc_z, measured_acc_z
  logic [1:0]  s_tuser = '0;   // op
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [47:0] m_tdata;        // throttle, gain, zero pad
  logic        m_tuser;        // updated
  logic        cfg_we = 0;
  logic [tmre_pkg::CFG_IDX_W-1:0]  cfg_addr = '0;
  logic [tmre_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  gain_scoreboard sb = new();
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        ticks = 0;
  int        n_in = 0;
  bit [31:0] clock_us;

  thrust_map_rls_estimator_unit uut (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // watchdog
  always @(posedge clk) begin
    ticks <= ticks + 1;
    if (ticks > MAX_TICKS) begin
      $display("timeout after %0d cycles, %0d beats outstanding", ticks, sb.pending.size());
      $display("** thrust_map_rls_estimator_unit: FAILED **");
      $finish;
    end
  end

  // output side: check accepted beats, stall at random
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_output(m_tdata[17:0], m_tuser, m_tdata[41:18]);
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_beat(tmre_pkg::op_t op, bit [31:0] now, bit [23:0] dem,
                           bit [23:0] meas);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser  <= op;
    s_tdata  <= {meas, dem, now};
    do @(posedge clk); while (!s_tready);
    sb.note_input(op, now, dem, meas);
    n_in++;
  endtask

  task automatic go_quiet();
    s_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // write enable stays high across back-to-back writes; the caller drops it
  task automatic write_reg(bit [2:0] idx, bit [20:0] val);
    cfg_we <= 1; cfg_addr <= idx; cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic load_setting(bit [20:0] g, bit [20:0] h, bit [20:0] f, bit [20:0] o,
                              bit [20:0] y);
    go_quiet();
    write_reg(tmre_pkg::CFG_GRAVITY, g);
    write_reg(tmre_pkg::CFG_HOVER, h);
    write_reg(tmre_pkg::CFG_FORGET, f);
    write_reg(tmre_pkg::CFG_OLDEST, o);
    write_reg(tmre_pkg::CFG_YOUNGEST, y);
    cfg_we <= 0;
    @(posedge clk);
    send_beat(tmre_pkg::OP_RST, clock_us, 0, 0);
  endtask

  function automatic bit [23:0] rand_acc();
    if ($urandom_range(3) == 0) return $urandom();
    return 24'($signed($urandom_range(0, 2 ** 21)) - 2 ** 20);
  endfunction

  // mostly well-formed command / estimate traffic on an advancing clock
  task automatic random_traffic(int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 45) send_beat(tmre_pkg::OP_CMD, clock_us, rand_acc(), 0);
      else if (r < 85) send_beat(tmre_pkg::OP_EST, clock_us, $urandom(), rand_acc());
      else if (r < 90) send_beat(tmre_pkg::OP_RST, clock_us, $urandom(), $urandom());
      else if (r < 93) send_beat(tmre_pkg::OP_NOP, clock_us, $urandom(), $urandom());
      else send_beat(tmre_pkg::op_t'($urandom_range(3)), $urandom(), $urandom(), $urandom());
      clock_us += $urandom_range(500, 8000);
    end
  endtask

  // overfill the history, then run estimates against its oldest entries
  task automatic burst_fill();
    for (int i = 0; i < 110; i++) begin
      send_beat(tmre_pkg::OP_CMD, clock_us, rand_acc(), 0);
      clock_us += 10;
    end
    clock_us += 40000;
    for (int i = 0; i < 10; i++) begin
      send_beat(tmre_pkg::OP_EST, clock_us, 0, rand_acc());
      clock_us += 5;
    end
  endtask

  initial begin
    sb.power_on();
    clock_us = 32'd1000;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: empty history, field extremes, too recent, usable, stale
    send_beat(tmre_pkg::OP_EST, clock_us, 0, 24'h7FFFFF);
    send_beat(tmre_pkg::OP_CMD, clock_us, 24'h7FFFFF, 0);
    send_beat(tmre_pkg::OP_CMD, clock_us + 1, 24'h800000, 0);
    send_beat(tmre_pkg::OP_CMD, clock_us + 2, 24'h000000, 0);
    send_beat(tmre_pkg::OP_CMD, clock_us + 3, 24'hFFFFFF, 0);
    send_beat(tmre_pkg::OP_EST, clock_us + 100, 0, 24'h123456);
    send_beat(tmre_pkg::OP_EST, clock_us + 35000, 0, 24'h7FFFFF);
    send_beat(tmre_pkg::OP_EST, clock_us + 35001, 0, 24'h800000);
    send_beat(tmre_pkg::OP_NOP, 32'hFFFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_beat(tmre_pkg::OP_EST, clock_us + 90000, 0, 0);
    send_beat(tmre_pkg::OP_RST, 0, 0, 0);
    send_beat(tmre_pkg::OP_CMD, clock_us + 90000, 24'h0A0000, 0);
    send_beat(tmre_pkg::OP_EST, clock_us + 126000, 24'hFFFFFF, 24'h0A0000);
    clock_us += 200000;

    // sender 37 / receiver 74 percent idle
    send_idle_pct = 37; recv_idle_pct = 74;
    random_traffic(200);
    load_setting(21'd0, 21'd65535, 21'd32768, 21'd1000000, 21'd0);
    random_traffic(150);

    // hold off until the pipeline drains, then carry on
    go_quiet();
    send_idle_pct = 74; recv_idle_pct = 37;
    load_setting(21'd1310720, 21'd1, 21'd65536, 21'd0, 21'd0);
    random_traffic(120);
    clock_us = 32'hFFFE0000;
    load_setting(21'd642908, 21'd0, 21'd0, 21'd45000, 21'd60000);
    random_traffic(120);
    load_setting(21'd800000, 21'd30000, 21'd60000, 21'd100000, 21'd20000);
    burst_fill();
    random_traffic(100);

    // no idling
    send_idle_pct = 0; recv_idle_pct = 0;
    load_setting(tmre_pkg::GRAVITY_RST, tmre_pkg::HOVER_RST, tmre_pkg::FORGET_RST,
                 tmre_pkg::OLDEST_RST, tmre_pkg::YOUNGEST_RST);
    random_traffic(200);
    load_setting(21'd1000000, 21'd40000, 21'd50000, 21'd60000, 21'd30000);
    random_traffic(270);

    go_quiet();
    repeat (400) @(posedge clk);
    $display("%0d input beats, %0d output beats checked, %0d gain updates", n_in, sb.n_out,
             sb.n_upd);
    $display("seven register settings incl. zero gain, zero hover, wrap and overfull history");
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("** thrust_map_rls_estimator_unit: PASSED **");
    else
      $display("** thrust_map_rls_estimator_unit: FAILED **");
    $finish;
  end

endmodule
